// ----- hdl/lfu_cache_lru_tiebreak_defines.svh -----
// ----------------------------------------------------------------------------
// lfu_cache_lru_tiebreak_defines
// Assertion macros used by the cache controller.
// ----------------------------------------------------------------------------
`ifndef LFU_CACHE_LRU_TIEBREAK_DEFINES_SVH
`define LFU_CACHE_LRU_TIEBREAK_DEFINES_SVH
// Checks that a condition implies a consequence on the same edge.
`define LFC_ASSERT_IMP(label, clk, rst, cond, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
      else $error("assertion failed");
// Checks that a condition implies a consequence on the next edge.
`define LFC_ASSERT_NEXT(label, clk, rst, cond, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
      else $error("assertion failed");
`endif

// ----- hdl/lfc_pkg.sv -----
// ----------------------------------------------------------------------------
// lfc_pkg
// Shared types and constants of the LFU cache.
// ----------------------------------------------------------------------------
package lfc_pkg;
   localparam int KEY_W = 32;
   localparam int VAL_W = 32;
   localparam int CAP_W = 5;
   localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;
   localparam int ADDR_W = 1;
   localparam logic [ADDR_W-1:0] REG_CAPACITY = 1'b0;

   // commands from controller to datapath
   typedef struct packed {
      logic start;    // latch request, clear scan state
      logic scan;     // examine one slot
      logic evict;    // drop the chosen victim
      logic insert;   // place the new key, raise rank of all valid slots
      logic touch;    // bump hit slot
   } cmd_type;

   typedef struct packed {
      logic scan_last;
      logic found;
      logic full;
      logic victim_ok;
      logic free_ok;
      logic mode;
   } stat_type;
endpackage

// ----- hdl/lfc_if.sv -----
// ----------------------------------------------------------------------------
// lfc_if
// Valid/ready stream channel carrying a payload of generic type.
// ----------------------------------------------------------------------------
interface lfc_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// ----- hdl/lfc_datapath.sv -----
// ----------------------------------------------------------------------------
// lfc_datapath
// Slot storage, sequential key/victim scan and parallel slot update.
// ----------------------------------------------------------------------------
module lfc_datapath #(
   parameter int ENTRIES = 16,
   parameter int COUNT_BITS = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  lfc_pkg::cmd_type           cmd,
   output lfc_pkg::stat_type          stat,
   input  logic                       req_mode,
   input  logic [lfc_pkg::KEY_W-1:0]  req_key,
   input  logic [lfc_pkg::VAL_W-1:0]  req_value,
   input  logic [lfc_pkg::CAP_W-1:0]  capacity,
   output logic                       res_hit,
   output logic [lfc_pkg::VAL_W-1:0]  res_read_value,
   output logic                       res_evicted,
   output logic [lfc_pkg::KEY_W-1:0]  res_evicted_key
);
   localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int RANK_W = IDX_W;
   localparam int OCC_W = $clog2(ENTRIES + 1);
   localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

   logic [ENTRIES-1:0]              valid_ff, valid_in;
   logic [lfc_pkg::KEY_W-1:0]       key_ff [ENTRIES];
   logic [lfc_pkg::VAL_W-1:0]       val_ff [ENTRIES];
   logic [COUNT_BITS-1:0]           cnt_ff [ENTRIES];
   logic [RANK_W-1:0]               rank_ff [ENTRIES];

   logic                            mode_ff;
   logic [lfc_pkg::KEY_W-1:0]       rkey_ff;
   logic [lfc_pkg::VAL_W-1:0]       rval_ff;
   logic [IDX_W-1:0]                idx_ff, idx_in;
   logic                            found_ff;
   logic [IDX_W-1:0]                hit_ff;
   logic                            vic_ok_ff;
   logic [IDX_W-1:0]                vic_ff;
   logic                            free_ok_ff;
   logic [IDX_W-1:0]                free_ff;
   logic [OCC_W-1:0]                occ_ff;
   logic                            ev_ff;
   logic [lfc_pkg::KEY_W-1:0]       evk_ff;
   logic [lfc_pkg::VAL_W-1:0]       rd_ff;

   logic [lfc_pkg::CAP_W-1:0]       cap_eff;
   logic                            better;
   logic [RANK_W-1:0]               ref_rank;

   always_comb begin
      if (capacity == '0) begin
         cap_eff = lfc_pkg::CAP_W'(1);
      end else if (32'(capacity) > ENTRIES) begin
         cap_eff = lfc_pkg::CAP_W'(ENTRIES);
      end else begin
         cap_eff = capacity;
      end
   end

   always_comb begin
      better = !vic_ok_ff || cnt_ff[idx_ff] < cnt_ff[vic_ff] ||
               (cnt_ff[idx_ff] == cnt_ff[vic_ff] && rank_ff[idx_ff] > rank_ff[vic_ff]);
   end

   // rank of the touched or dropped slot, used by the parallel rank update
   assign ref_rank = cmd.evict ? rank_ff[vic_ff] : rank_ff[hit_ff];

   always_comb begin
      idx_in = (cmd.start || idx_ff == LAST_IDX) ? '0 : idx_ff + 1'b1;
      valid_in = valid_ff;
      if (cmd.evict && vic_ok_ff) begin
         valid_in[vic_ff] = 1'b0;
      end
      if (cmd.insert && free_ok_ff) begin
         valid_in[free_ff] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         idx_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         if (cmd.start || cmd.scan) begin
            idx_ff <= idx_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         mode_ff    <= req_mode;
         rkey_ff    <= req_key;
         rval_ff    <= req_value;
         found_ff   <= 1'b0;
         vic_ok_ff  <= 1'b0;
         free_ok_ff <= 1'b0;
         occ_ff     <= '0;
         ev_ff      <= 1'b0;
         evk_ff     <= '0;
         hit_ff     <= '0;
         vic_ff     <= '0;
         free_ff    <= '0;
      end
      if (cmd.scan) begin
         if (valid_ff[idx_ff]) begin
            occ_ff <= occ_ff + 1'b1;
            if (key_ff[idx_ff] == rkey_ff) begin
               found_ff <= 1'b1;
               hit_ff   <= idx_ff;
            end
            if (better) begin
               vic_ok_ff <= 1'b1;
               vic_ff    <= idx_ff;
            end
         end else if (!free_ok_ff) begin
            free_ok_ff <= 1'b1;
            free_ff    <= idx_ff;
         end
      end
      if (cmd.evict && vic_ok_ff) begin
         ev_ff  <= 1'b1;
         evk_ff <= key_ff[vic_ff];
         // the victim slot is now the lowest free one if none was free or it sits below
         if (!free_ok_ff || vic_ff < free_ff) begin
            free_ok_ff <= 1'b1;
            free_ff    <= vic_ff;
         end
         for (int j = 0; j < ENTRIES; j++) begin
            if (valid_ff[j] && IDX_W'(j) != vic_ff && rank_ff[j] > ref_rank) begin
               rank_ff[j] <= rank_ff[j] - 1'b1;
            end
         end
      end
      if (cmd.insert && free_ok_ff) begin
         for (int j = 0; j < ENTRIES; j++) begin
            if (valid_ff[j]) begin
               rank_ff[j] <= rank_ff[j] + 1'b1;
            end
         end
         key_ff[free_ff]  <= rkey_ff;
         val_ff[free_ff]  <= rval_ff;
         cnt_ff[free_ff]  <= COUNT_BITS'(1);
         rank_ff[free_ff] <= '0;
      end
      if (cmd.touch) begin
         for (int j = 0; j < ENTRIES; j++) begin
            if (valid_ff[j] && IDX_W'(j) != hit_ff && rank_ff[j] < ref_rank) begin
               rank_ff[j] <= rank_ff[j] + 1'b1;
            end
         end
         rank_ff[hit_ff] <= '0;
         if (cnt_ff[hit_ff] != CNT_MAX) begin
            cnt_ff[hit_ff] <= cnt_ff[hit_ff] + 1'b1;
         end
         rd_ff <= mode_ff ? '0 : val_ff[hit_ff];
         if (mode_ff) begin
            val_ff[hit_ff] <= rval_ff;
         end
      end
   end

   assign stat.scan_last = (idx_ff == LAST_IDX);
   assign stat.found     = found_ff;
   assign stat.full      = (32'(occ_ff) >= 32'(cap_eff));
   assign stat.victim_ok = vic_ok_ff;
   assign stat.free_ok   = free_ok_ff;
   assign stat.mode      = mode_ff;

   assign res_hit         = found_ff;
   assign res_read_value  = found_ff ? rd_ff : (mode_ff ? '0 : '1);
   assign res_evicted     = ev_ff;
   assign res_evicted_key = evk_ff;
endmodule

// ----- hdl/lfc_ctrl.sv -----
// ----------------------------------------------------------------------------
// lfc_ctrl
// Request sequencer: accept, scan, update, hold the response beat.
// ----------------------------------------------------------------------------
`include "lfu_cache_lru_tiebreak_defines.svh"
module lfc_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output lfc_pkg::cmd_type   cmd,
   input  lfc_pkg::stat_type  stat
);
   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_SCAN  = 3'd1;
   localparam logic [2:0] ST_EVICT = 3'd2;
   localparam logic [2:0] ST_INS   = 3'd3;
   localparam logic [2:0] ST_TOUCH = 3'd4;
   localparam logic [2:0] ST_RESP  = 3'd5;

   logic [2:0] state_ff, state_in;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = (state_ff == ST_RESP);

   always_comb begin
      cmd = '0;
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.start = 1'b1;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (stat.scan_last) begin
               state_in = ST_EVICT;
            end
         end
         ST_EVICT: begin
            if (stat.found) begin
               state_in = ST_TOUCH;
            end else if (!stat.mode) begin
               state_in = ST_RESP;
            end else begin
               cmd.evict = stat.full;
               state_in = ST_INS;
            end
         end
         ST_INS: begin
            cmd.insert = 1'b1;
            state_in = ST_RESP;
         end
         ST_TOUCH: begin
            cmd.touch = 1'b1;
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   `LFC_ASSERT_NEXT(a_start_scan, clock, reset, req_valid && req_ready, state_ff == ST_SCAN)
   `LFC_ASSERT_IMP(a_one_side, clock, reset, 1'b1, !(req_ready && rsp_valid))
   `LFC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   `LFC_ASSERT_IMP(a_insert_free, clock, reset, cmd.insert, stat.free_ok)
   `LFC_ASSERT_IMP(a_evict_victim, clock, reset, cmd.evict, stat.victim_ok)
endmodule

// ----- hdl/lfu_cache_lru_tiebreak.sv -----
// Sequence: a request beat is followed by the slot scan, the evict decision, the
// update step and the response beat; a get miss skips the update step.
// One request at a time: the next is accepted only after the response beat, the
// scan takes one slot a cycle, and the next request is taken the cycle after the beat.
// Reset (synchronous, high): all slots invalid, capacity 16, no clearing pass.
// ----------------------------------------------------------------------------
// lfu_cache_lru_tiebreak
// LFU key-value cache with LRU tie-break, APB-style capacity register.
// ----------------------------------------------------------------------------
module lfu_cache_lru_tiebreak #(
   parameter int ENTRIES = 16,
   parameter int COUNT_BITS = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   lfc_if.sink                          req,
   lfc_if.source                        rsp,
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [lfc_pkg::ADDR_W+1:0]   csr_paddr,
   input  logic [31:0]                  csr_pwdata,
   output logic [31:0]                  csr_prdata,
   output logic                         csr_pready
);
   lfc_pkg::cmd_type  cmd;
   lfc_pkg::stat_type stat;
   logic [lfc_pkg::CAP_W-1:0] cap_ff;
   logic is_cap;

   assign csr_pready = 1'b1;
   assign is_cap = (csr_paddr[lfc_pkg::ADDR_W+1:2] == lfc_pkg::REG_CAPACITY);
   assign csr_prdata = is_cap ? {27'd0, cap_ff} : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= lfc_pkg::CAP_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite && is_cap) begin
         cap_ff <= csr_pwdata[lfc_pkg::CAP_W-1:0];
      end
   end

   lfc_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .req_valid(req.valid), .req_ready(req.ready),
      .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
      .cmd(cmd), .stat(stat)
   );

   lfc_datapath #(.ENTRIES(ENTRIES), .COUNT_BITS(COUNT_BITS)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .stat(stat),
      .req_mode(req.data.mode), .req_key(req.data.key), .req_value(req.data.value),
      .capacity(cap_ff),
      .res_hit(rsp.data.hit), .res_read_value(rsp.data.read_value),
      .res_evicted(rsp.data.evicted), .res_evicted_key(rsp.data.evicted_key)
   );
endmodule

// ----- dv/lfu_cache_lru_tiebreak_tb.sv -----
// ----------------------------------------------------------------------------
// lfu_cache_lru_tiebreak_tb
// Self-checking bench for the LFU cache: a scoreboard model predicts the
// response to each request beat, and every response beat is compared with it.
// ----------------------------------------------------------------------------
module lfu_cache_lru_tiebreak_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SLOTS = 16;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam logic [15:0] COUNT_TOP = 16'hFFFF;

   typedef enum logic {OP_GET = 1'b0, OP_PUT = 1'b1} op_type;

   typedef struct packed {
      logic                       mode;
      logic [lfc_pkg::KEY_W-1:0]  key;
      logic [lfc_pkg::VAL_W-1:0]  value;
   } req_type;

   typedef struct packed {
      logic                       hit;
      logic [lfc_pkg::VAL_W-1:0]  read_value;
      logic                       evicted;
      logic [lfc_pkg::KEY_W-1:0]  evicted_key;
   } rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_psel, csr_penable, csr_pwrite;
   logic [lfc_pkg::ADDR_W+1:0] csr_paddr;
   logic [31:0] csr_pwdata, csr_prdata;
   logic csr_pready;

   lfc_if #(.payload_type(req_type)) req_ch ();
   lfc_if #(.payload_type(rsp_type)) rsp_ch ();

   lfu_cache_lru_tiebreak dut (
      .clock(clock), .reset(reset), .req(req_ch), .rsp(rsp_ch),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always #2 clock = ~clock;

   // cache shadow
   logic [lfc_pkg::CAP_W-1:0] cap_reg;
   logic                       sh_valid [SLOTS];
   logic [lfc_pkg::KEY_W-1:0]  sh_key   [SLOTS];
   logic [lfc_pkg::VAL_W-1:0]  sh_val   [SLOTS];
   logic [15:0]                sh_count [SLOTS];
   int unsigned                sh_rank  [SLOTS];

   rsp_type pending_rsp[$];
   int errors = 0;
   int send_idle_pct = 0;
   int stall_pct = 0;
   int idle_cycles = 0;
   logic [lfc_pkg::KEY_W-1:0] key_pool [24];

   function automatic void bump_slot(int s);
      for (int j = 0; j < SLOTS; j++)
         if (sh_valid[j] && j != s && sh_rank[j] < sh_rank[s]) sh_rank[j]++;
      sh_rank[s] = 0;
      if (sh_count[s] != COUNT_TOP) sh_count[s]++;
   endfunction

   function automatic rsp_type cache_lookup(req_type r);
      rsp_type o;
      int s, v, f, used, lim;
      o = '0;
      s = -1;
      v = -1;
      f = -1;
      used = 0;
      lim = (cap_reg == 0) ? 1 : (cap_reg > SLOTS) ? SLOTS : int'(cap_reg);
      for (int i = SLOTS - 1; i >= 0; i--)
         if (sh_valid[i] && sh_key[i] == r.key) s = i;
      if (r.mode == OP_GET) begin
         if (s >= 0) begin
            o.hit = 1'b1;
            o.read_value = sh_val[s];
            bump_slot(s);
         end else begin
            o.read_value = '1;
         end
      end else if (s >= 0) begin
         o.hit = 1'b1;
         sh_val[s] = r.value;
         bump_slot(s);
      end else begin
         for (int i = 0; i < SLOTS; i++) if (sh_valid[i]) used++;
         if (used >= lim) begin
            for (int i = 0; i < SLOTS; i++)
               if (sh_valid[i] && (v < 0 || sh_count[i] < sh_count[v] ||
                   (sh_count[i] == sh_count[v] && sh_rank[i] > sh_rank[v]))) v = i;
            if (v >= 0) begin
               o.evicted = 1'b1;
               o.evicted_key = sh_key[v];
               for (int j = 0; j < SLOTS; j++)
                  if (sh_valid[j] && j != v && sh_rank[j] > sh_rank[v]) sh_rank[j]--;
               sh_valid[v] = 1'b0;
            end
         end
         for (int i = SLOTS - 1; i >= 0; i--) if (!sh_valid[i]) f = i;
         if (f >= 0) begin
            for (int j = 0; j < SLOTS; j++) if (sh_valid[j]) sh_rank[j]++;
            sh_valid[f] = 1'b1;
            sh_key[f] = r.key;
            sh_val[f] = r.value;
            sh_count[f] = 16'd1;
            sh_rank[f] = 0;
         end
      end
      return o;
   endfunction

   // Call only at a rising edge; returns at the edge that takes the beat.
   task automatic send_request(op_type op, logic [lfc_pkg::KEY_W-1:0] k,
                               logic [lfc_pkg::VAL_W-1:0] v);
      req_type r;
      r.mode = op;
      r.key = k;
      r.value = v;
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.data <= r;
      do @(posedge clock); while (!req_ch.ready);
      pending_rsp.push_back(cache_lookup(r));
   endtask

   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
   endtask

   task automatic write_capacity(logic [31:0] val);
      wait_drained();
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {lfc_pkg::REG_CAPACITY, 2'b00};
      csr_pwdata <= val;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      cap_reg = val[lfc_pkg::CAP_W-1:0];
      @(posedge clock);
   endtask

   // response check, receiver stalls and watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (pending_rsp.size() == 0) begin
               errors++;
               $display("%0t: unexpected response beat %h", $time, rsp_ch.data);
            end else begin
               rsp_type e;
               e = pending_rsp.pop_front();
               if (e.hit !== rsp_ch.data.hit) begin
                  errors++;
                  $display("%0t: hit exp %b got %b", $time, e.hit, rsp_ch.data.hit);
               end
               if (e.read_value !== rsp_ch.data.read_value) begin
                  errors++;
                  $display("%0t: read_value exp %h got %h", $time, e.read_value,
                           rsp_ch.data.read_value);
               end
               if (e.evicted !== rsp_ch.data.evicted) begin
                  errors++;
                  $display("%0t: evicted exp %b got %b", $time, e.evicted,
                           rsp_ch.data.evicted);
               end
               if (e.evicted_key !== rsp_ch.data.evicted_key) begin
                  errors++;
                  $display("%0t: evicted_key exp %h got %h", $time, e.evicted_key,
                           rsp_ch.data.evicted_key);
               end
            end
         end
         if ((rsp_ch.valid && rsp_ch.ready) || (req_ch.valid && req_ch.ready))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
         end
      end
      rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
   end

   task automatic test_basic();
      write_capacity(32'd16);
      send_request(OP_GET, 32'h0000_0000, 32'h0);
      send_request(OP_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
      send_request(OP_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
      send_request(OP_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_request(OP_PUT, 32'h0000_0000, 32'h0000_0000);
      send_request(OP_GET, 32'h8000_0000, 32'h1234_5678);
      send_request(OP_GET, 32'hFFFF_FFFF, 32'h0);
      send_request(OP_PUT, 32'h7FFF_FFFF, 32'h5555_AAAA);
      send_request(OP_GET, 32'h7FFF_FFFF, 32'h0);
      send_request(OP_GET, 32'h0000_0001, 32'h0);
   endtask

   task automatic test_capacity();
      // zero acts as one
      write_capacity(32'd0);
      send_request(OP_PUT, 32'h10, 32'h1);
      send_request(OP_PUT, 32'h11, 32'h2);
      // above the slot count saturates
      write_capacity(32'd31);
      for (int i = 0; i < 18; i++) send_request(OP_PUT, 32'h100 + i, i);
      // lower below occupancy: one out, one in
      write_capacity(32'd3);
      send_request(OP_PUT, 32'h200, 32'h9);
      send_request(OP_GET, 32'h200, 32'h0);
      write_capacity(32'd1);
      send_request(OP_PUT, 32'h201, 32'h8);
   endtask

   task automatic test_tiebreak();
      write_capacity(32'd0);
      send_request(OP_PUT, 32'h300, 32'h0);
      for (int i = 0; i < SLOTS; i++) send_request(OP_PUT, 32'h300, i);
      write_capacity(32'd2);
      send_request(OP_PUT, 32'hA, 32'h1);
      send_request(OP_PUT, 32'hB, 32'h2);
      send_request(OP_GET, 32'hA, 32'h0);
      send_request(OP_PUT, 32'hC, 32'h3);
      send_request(OP_PUT, 32'hD, 32'h4);
   endtask

   task automatic test_count_priority();
      // a heavily used key survives newer keys
      write_capacity(32'd2);
      send_request(OP_PUT, 32'h5A5A_0001, 32'h77);
      for (int i = 0; i < 40; i++) send_request(OP_GET, 32'h5A5A_0001, 32'h0);
      send_request(OP_PUT, 32'h5A5A_0002, 32'h1);
      send_request(OP_PUT, 32'h5A5A_0003, 32'h2);
      send_request(OP_GET, 32'h5A5A_0001, 32'h0);
   endtask

   task automatic test_random(int idle, int stall, logic [31:0] cap, int n);
      logic [lfc_pkg::KEY_W-1:0] k;
      write_capacity(cap);
      send_idle_pct = idle;
      stall_pct = stall;
      for (int i = 0; i < n; i++) begin
         k = ($urandom_range(99) < 80) ? key_pool[$urandom_range(23)] : $urandom;
         send_request(op_type'($urandom_range(1)), k, $urandom);
         if (i == n / 2) wait_drained();
      end
      send_idle_pct = 0;
      stall_pct = 0;
   endtask

   initial begin
      req_ch.valid = 1'b0;
      req_ch.data = '0;
      rsp_ch.ready = 1'b1;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      cap_reg = lfc_pkg::CAP_RESET;
      for (int i = 0; i < SLOTS; i++) begin
         sh_valid[i] = 1'b0;
         sh_key[i] = '0;
         sh_val[i] = '0;
         sh_count[i] = '0;
         sh_rank[i] = 0;
      end
      for (int i = 0; i < 24; i++) key_pool[i] = $urandom;
      key_pool[0] = 32'h8000_0000;
      key_pool[1] = 32'h7FFF_FFFF;
      key_pool[2] = 32'hFFFF_FFFF;
      key_pool[3] = 32'h0000_0000;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_basic();
      test_capacity();
      test_tiebreak();
      test_count_priority();
      test_random(0, 0, 32'd16, 225);
      test_random(50, 0, 32'd4, 225);
      test_random(0, 50, 32'd31, 225);
      test_random(24, 24, 32'd1, 225);
      wait_drained();
      repeat (30) @(posedge clock);
      if (errors == 0 && pending_rsp.size() == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end
endmodule

// ----- sim.f -----
+incdir+hdl
hdl/lfc_pkg.sv
hdl/lfc_if.sv
hdl/lfc_datapath.sv
hdl/lfc_ctrl.sv
hdl/lfu_cache_lru_tiebreak.sv
dv/lfu_cache_lru_tiebreak_tb.sv
